@@ rtl/core/vot_pkg.sv @@
// shared types, constants and helper functions of the voronoi owner and halo test block
package vot_pkg;

  localparam int CW      = 32;          // coordinate width
  localparam int DW      = CW + 2;      // wrapped difference width
  localparam int AW      = CW + 3;      // image offset width
  localparam int RW      = 31;          // radius and box length width
  localparam int IW      = 6;           // table index width
  localparam int CNTW    = 7;           // entry count width
  localparam int MAX_GEN = 64;
  localparam int LIMB    = 32;
  localparam int OPW     = 3 * LIMB;    // multiply operand width
  localparam int ACCW    = 5 * LIMB;    // accumulator width
  localparam int LCW     = 2;           // limb count width
  localparam int REGW    = 3;           // register index width
  localparam int STW     = 4;           // micro step width

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_OWNER = 2'd1;
  localparam logic [1:0] FUNC_NEAR  = 2'd2;

  localparam logic [REGW-1:0] REG_OWN_INDEX     = 3'd0;
  localparam logic [REGW-1:0] REG_CENTER_COUNT  = 3'd1;
  localparam logic [REGW-1:0] REG_DIMENSIONS    = 3'd2;
  localparam logic [REGW-1:0] REG_PERIODIC_MASK = 3'd3;
  localparam logic [REGW-1:0] REG_BOX_X         = 3'd4;
  localparam logic [REGW-1:0] REG_BOX_Y         = 3'd5;
  localparam logic [REGW-1:0] REG_BOX_Z         = 3'd6;

  // micro steps of the multiply sequence
  localparam logic [STW-1:0] STEP_SQ  = 4'd0;   // three squared axes
  localparam logic [STW-1:0] STEP_DOT = 4'd3;   // three 2*G*v terms
  localparam logic [STW-1:0] STEP_NN  = 4'd6;   // N*N
  localparam logic [STW-1:0] STEP_GR  = 4'd7;   // minus |G|^2 * r2
  localparam logic [STW-1:0] STEP_R2  = 4'd8;   // (2R)^2

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OWN_RD,
    ST_OWN_LOAD,
    ST_OWN_CMP,
    ST_NEAR_RD_OWN,
    ST_NEAR_RD_NB,
    ST_NEAR_LOAD,
    ST_NEAR_PREP,
    ST_IMAGE,
    ST_MAC_GO,
    ST_MAC_WAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [RW-1:0]        radius;
  } gen_t;

  typedef struct packed {
    logic           start;
    logic           clear;
    logic           sub;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    logic [LCW-1:0] na;
    logic [LCW-1:0] nb;
  } mac_req_t;

  // minimum image: add or subtract the box length at most once
  function automatic logic signed [DW-1:0] wrap_diff(input logic signed [CW:0] d,
                                                     input logic [RW-1:0] len,
                                                     input logic per);
    logic signed [DW:0]   d2;
    logic signed [DW:0]   lw;
    logic signed [DW-1:0] de;
    logic signed [DW-1:0] le;
    d2 = {d[CW], d, 1'b0};
    lw = {{(DW + 1 - RW){1'b0}}, len};
    de = {d[CW], d};
    le = {{(DW - RW){1'b0}}, len};
    if (per && (d2 < -lw)) begin
      wrap_diff = de + le;
    end else if (per && (d2 > lw)) begin
      wrap_diff = de - le;
    end else begin
      wrap_diff = de;
    end
  endfunction

  function automatic logic [AW-1:0] mag_of(input logic signed [AW-1:0] x);
    mag_of = x[AW-1] ? ($unsigned(~x) + AW'(1)) : $unsigned(x);
  endfunction

endpackage

@@ rtl/core/vot_table.sv @@
// generator table: one write port, one registered read port
module vot_table (
  input  logic                  clk,
  input  logic                  we,
  input  logic [vot_pkg::IW-1:0] waddr,
  input  vot_pkg::gen_t         wdata,
  input  logic [vot_pkg::IW-1:0] raddr,
  output vot_pkg::gen_t         rdata
);
  import vot_pkg::*;

  gen_t mem [MAX_GEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/vot_mac.sv @@
// shared multiply-accumulate unit: one 32x32 partial product per cycle into a wide accumulator
module vot_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  vot_pkg::mac_req_t              req,
  output logic                           done,
  output logic signed [vot_pkg::ACCW-1:0] acc
);
  import vot_pkg::*;

  logic [OPW-1:0]  a_q;
  logic [OPW-1:0]  b_q;
  logic [LCW-1:0]  na_q;
  logic [LCW-1:0]  nb_q;
  logic [LCW-1:0]  ia;
  logic [LCW-1:0]  ib;
  logic            busy;
  logic            sub_q;
  logic            pp_valid;
  logic            pp_last;
  logic            pp_sub;
  logic [2:0]      pp_off;
  logic [2*LIMB-1:0] prod;
  logic [LIMB-1:0] a_limb;
  logic [LIMB-1:0] b_limb;
  logic            last_pp;
  logic [ACCW-1:0] addend;

  always_comb begin
    a_limb  = a_q[{ia, 5'b0} +: LIMB];
    b_limb  = b_q[{ib, 5'b0} +: LIMB];
    last_pp = (ia == na_q - 2'd1) && (ib == nb_q - 2'd1);
    addend  = {{(ACCW - 2 * LIMB){1'b0}}, prod} << {pp_off, 5'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pp_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= pp_valid && pp_last;
      pp_valid <= busy;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last_pp) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_q   <= req.a;
      b_q   <= req.b;
      na_q  <= req.na;
      nb_q  <= req.nb;
      sub_q <= req.sub;
      ia    <= '0;
      ib    <= '0;
    end else if (busy) begin
      if (ib == nb_q - 2'd1) begin
        ib <= '0;
        ia <= ia + 2'd1;
      end else begin
        ib <= ib + 2'd1;
      end
    end
    prod    <= a_limb * b_limb;
    pp_off  <= {1'b0, ia} + {1'b0, ib};
    pp_last <= last_pp;
    pp_sub  <= sub_q;
    if (req.start && req.clear) begin
      acc <= '0;
    end else if (pp_valid) begin
      acc <= pp_sub ? (acc - $signed(addend)) : (acc + $signed(addend));
    end
  end

endmodule

@@ rtl/core/voronoi_owner_and_halo_test.sv @@
// top level: periodic voronoi owner search and halo test over a generator table
// owner query: table entries are searched in turn, the time per entry set by the
//   shared 32x32 multiplier doing four partial products per squared axis
// near query: setup reads the own and neighbour entries, then up to 8 images are tested
// a table write is taken in the idle state; one transaction is in work at a time
// reset is synchronous: control registers get defaults; table and data stay unknown
module voronoi_owner_and_halo_test (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vot_pkg::REGW-1:0]      cfg_index,
  input  logic [vot_pkg::RW-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [vot_pkg::IW-1:0]        entry_index,
  input  logic signed [vot_pkg::CW-1:0] point_x,
  input  logic signed [vot_pkg::CW-1:0] point_y,
  input  logic signed [vot_pkg::CW-1:0] point_z,
  input  logic [vot_pkg::RW-1:0]        halo_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          answer_kind,
  output logic [vot_pkg::IW-1:0]        owner_index,
  output logic                          is_near
);
  import vot_pkg::*;

  // configuration
  logic [IW-1:0]   own_idx;
  logic [CNTW-1:0] center_count;
  logic [1:0]      dims;
  logic [2:0]      pmask;
  logic [RW-1:0]   box_len [3];

  state_t state, state_next;

  logic [1:0]           func_q;
  logic [IW-1:0]        idx_q;
  logic signed [CW-1:0] p_q [3];
  logic [CNTW-1:0]      n_q;
  logic [CNTW-1:0]      i_q;
  logic signed [CW-1:0] co [3];
  logic signed [CW-1:0] cn [3];
  logic [RW-1:0]        ro;
  logic [RW-1:0]        rn;
  logic signed [DW-1:0] gv [3];
  logic signed [DW-1:0] vv [3];
  logic [2:0]           has;
  logic [AW-1:0]        sq_op [3];
  logic [AW:0]          dot_a [3];
  logic [AW-1:0]        dot_b [3];
  logic [2:0]           same;
  logic [RW:0]          r_big;
  logic [2*LIMB-1:0]    r2;
  logic [79:0]          gg;
  logic [79:0]          nn;
  logic [79:0]          best;
  logic [IW-1:0]        res_owner;
  logic                 near_res;
  logic [STW-1:0]       step;
  logic [2:0]           img;

  gen_t           rdata;
  gen_t           wdata;
  logic [IW-1:0]  raddr;
  logic           tbl_we;
  mac_req_t       mac_req;
  logic           mac_done;
  logic signed [ACCW-1:0] acc;

  logic                 in_acc;
  logic [CNTW-1:0]      n_eff;
  logic [2:0]           used;
  logic signed [CW-1:0] rd_c [3];
  logic signed [CW:0]   d_own [3];
  logic signed [CW:0]   d_g [3];
  logic signed [CW:0]   d_v [3];
  logic signed [DW-1:0] w_own [3];
  logic signed [DW-1:0] w_g [3];
  logic signed [DW-1:0] w_v [3];
  logic signed [AW-1:0] g_ext [3];
  logic signed [AW-1:0] alt [3];
  logic signed [AW-1:0] gsel [3];
  logic signed [AW-1:0] len_ext [3];
  logic [2:0]           sel;
  logic                 img_skip;
  logic                 img_last;
  logic                 entry_last;
  logic                 acc_zero;
  logic                 acc_le0;
  logic                 owner_mode;
  logic                 out_free;
  logic [1:0]           axis;

  vot_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (entry_index),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  vot_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .req  (mac_req),
    .done (mac_done),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      own_idx      <= '0;
      center_count <= CNTW'(MAX_GEN);
      dims         <= 2'd3;
      pmask        <= '0;
      box_len[0]   <= RW'(65536);
      box_len[1]   <= RW'(65536);
      box_len[2]   <= RW'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_INDEX:     own_idx      <= cfg_data[IW-1:0];
        REG_CENTER_COUNT:  center_count <= cfg_data[CNTW-1:0];
        REG_DIMENSIONS:    dims         <= cfg_data[1:0];
        REG_PERIODIC_MASK: pmask        <= cfg_data[2:0];
        REG_BOX_X:         box_len[0]   <= cfg_data;
        REG_BOX_Y:         box_len[1]   <= cfg_data;
        REG_BOX_Z:         box_len[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_acc     = in_valid && in_ready;
    tbl_we     = in_acc && (func == FUNC_WRITE);
    wdata      = '{x: point_x, y: point_y, z: point_z, radius: halo_radius};
    n_eff      = (center_count > CNTW'(MAX_GEN)) ? CNTW'(MAX_GEN) : center_count;
    rd_c[0]    = rdata.x;
    rd_c[1]    = rdata.y;
    rd_c[2]    = rdata.z;
    sel        = {img[0], img[1], img[2]};
    img_skip   = (img[2] && !has[0]) || (img[1] && !has[1]) || (img[0] && !has[2]);
    img_last   = (img == 3'd7);
    entry_last = ((i_q + CNTW'(1)) == n_q);
    acc_zero   = (acc == '0);
    acc_le0    = acc[ACCW-1] || acc_zero;
    owner_mode = (func_q == FUNC_OWNER);
    out_free   = !out_valid || out_ready;
    for (int k = 0; k < 3; k++) begin
      used[k]    = (k < int'(dims));
      d_own[k]   = {rd_c[k][CW-1], rd_c[k]} - {p_q[k][CW-1], p_q[k]};
      d_g[k]     = {cn[k][CW-1], cn[k]} - {co[k][CW-1], co[k]};
      d_v[k]     = {p_q[k][CW-1], p_q[k]} - {co[k][CW-1], co[k]};
      w_own[k]   = wrap_diff(d_own[k], box_len[k], pmask[k]);
      w_g[k]     = wrap_diff(d_g[k], box_len[k], pmask[k]);
      w_v[k]     = wrap_diff(d_v[k], box_len[k], pmask[k]);
      g_ext[k]   = {gv[k][DW-1], gv[k]};
      len_ext[k] = {{(AW - RW){1'b0}}, box_len[k]};
      // second image goes toward the other side, g of zero goes to g + L
      alt[k]     = (!g_ext[k][AW-1] && (g_ext[k] != '0)) ? (g_ext[k] - len_ext[k])
                                                         : (g_ext[k] + len_ext[k]);
      gsel[k]    = sel[k] ? alt[k] : g_ext[k];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (func == FUNC_OWNER)) begin
          state_next = (n_eff == '0) ? ST_RESULT : ST_OWN_RD;
        end else if (in_acc && (func == FUNC_NEAR)) begin
          state_next = ST_NEAR_RD_OWN;
        end
      end
      ST_OWN_RD:      state_next = ST_OWN_LOAD;
      ST_OWN_LOAD:    state_next = ST_MAC_GO;
      ST_OWN_CMP:     state_next = entry_last ? ST_RESULT : ST_OWN_RD;
      ST_NEAR_RD_OWN: state_next = ST_NEAR_RD_NB;
      ST_NEAR_RD_NB:  state_next = ST_NEAR_LOAD;
      ST_NEAR_LOAD:   state_next = ST_NEAR_PREP;
      ST_NEAR_PREP:   state_next = ST_MAC_GO;
      ST_IMAGE: begin
        if (img_skip) begin
          state_next = img_last ? ST_RESULT : ST_IMAGE;
        end else begin
          state_next = ST_MAC_GO;
        end
      end
      ST_MAC_GO:      state_next = ST_MAC_WAIT;
      ST_MAC_WAIT: begin
        if (mac_done) begin
          if (owner_mode) begin
            state_next = (step == STEP_DOT - 4'd1) ? ST_OWN_CMP : ST_MAC_GO;
          end else if (step == STEP_R2) begin
            state_next = ST_IMAGE;
          end else if (step == STEP_DOT - 4'd1) begin
            state_next = acc_zero ? ST_RESULT : ST_MAC_GO;
          end else if (step == STEP_NN - 4'd1) begin
            state_next = acc_le0 ? ST_RESULT : ST_MAC_GO;
          end else if (step == STEP_GR) begin
            state_next = (acc_le0 || img_last) ? ST_RESULT : ST_IMAGE;
          end else begin
            state_next = ST_MAC_GO;
          end
        end
      end
      ST_RESULT:      state_next = out_free ? ST_IDLE : ST_RESULT;
      default:        state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_NEAR_RD_OWN: raddr = own_idx;
      ST_NEAR_RD_NB:  raddr = idx_q;
      default:        raddr = i_q[IW-1:0];
    endcase
    axis          = (step < STEP_DOT) ? step[1:0] : 2'(step - STEP_DOT);
    mac_req.start = (state == ST_MAC_GO);
    mac_req.clear = 1'b0;
    mac_req.sub   = 1'b0;
    mac_req.a     = '0;
    mac_req.b     = '0;
    mac_req.na    = 2'd1;
    mac_req.nb    = 2'd1;
    priority if (step < STEP_DOT) begin
      mac_req.a     = OPW'(sq_op[axis]);
      mac_req.b     = OPW'(sq_op[axis]);
      mac_req.na    = 2'd2;
      mac_req.nb    = 2'd2;
      mac_req.clear = (step == STEP_SQ);
    end else if (step < STEP_NN) begin
      mac_req.a     = OPW'(dot_a[axis]);
      mac_req.b     = OPW'(dot_b[axis]);
      mac_req.na    = 2'd2;
      mac_req.nb    = 2'd2;
      mac_req.sub   = same[axis];
    end else if (step == STEP_NN) begin
      mac_req.a     = OPW'(nn);
      mac_req.b     = OPW'(nn);
      mac_req.na    = 2'd3;
      mac_req.nb    = 2'd3;
      mac_req.clear = 1'b1;
    end else if (step == STEP_GR) begin
      mac_req.a     = OPW'(gg);
      mac_req.b     = OPW'(r2);
      mac_req.na    = 2'd3;
      mac_req.nb    = 2'd2;
      mac_req.sub   = 1'b1;
    end else begin
      mac_req.a     = OPW'(r_big);
      mac_req.b     = OPW'(r_big);
      mac_req.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_q    <= func;
      idx_q     <= entry_index;
      p_q[0]    <= point_x;
      p_q[1]    <= point_y;
      p_q[2]    <= point_z;
      n_q       <= n_eff;
      i_q       <= '0;
      res_owner <= '0;
      near_res  <= 1'b0;
    end
    case (state)
      ST_OWN_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          sq_op[k] <= used[k] ? mag_of({w_own[k][DW-1], w_own[k]}) : '0;
        end
        step <= STEP_SQ;
      end
      ST_NEAR_RD_NB: begin
        for (int k = 0; k < 3; k++) begin
          co[k] <= rd_c[k];
        end
        ro <= rdata.radius;
      end
      ST_NEAR_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          cn[k] <= rd_c[k];
        end
        rn <= rdata.radius;
      end
      ST_NEAR_PREP: begin
        for (int k = 0; k < 3; k++) begin
          gv[k]  <= used[k] ? w_g[k] : '0;
          vv[k]  <= used[k] ? w_v[k] : '0;
          has[k] <= used[k] && pmask[k];
        end
        r_big <= {((ro > rn) ? ro : rn), 1'b0};
        step  <= STEP_R2;
        img   <= '0;
      end
      ST_IMAGE: begin
        for (int k = 0; k < 3; k++) begin
          sq_op[k] <= mag_of(gsel[k]);
          dot_a[k] <= {mag_of(gsel[k]), 1'b0};
          dot_b[k] <= mag_of({vv[k][DW-1], vv[k]});
          // positive product lowers N
          same[k]  <= (gsel[k] != '0) && (vv[k] != '0) && (gsel[k][AW-1] == vv[k][DW-1]);
        end
        step <= STEP_SQ;
        if (img_skip && !img_last) begin
          img <= img + 3'd1;
        end
      end
      ST_MAC_WAIT: begin
        if (mac_done) begin
          if (owner_mode) begin
            if (step != STEP_DOT - 4'd1) begin
              step <= step + 4'd1;
            end
          end else if (step == STEP_R2) begin
            r2 <= acc[2*LIMB-1:0];
          end else if (step == STEP_DOT - 4'd1) begin
            gg       <= acc[79:0];
            near_res <= acc_zero;
            step     <= step + 4'd1;
          end else if (step == STEP_NN - 4'd1) begin
            nn       <= acc[79:0];
            near_res <= acc_le0;
            step     <= step + 4'd1;
          end else if (step == STEP_GR) begin
            near_res <= acc_le0;
            img      <= img + 3'd1;
          end else begin
            step <= step + 4'd1;
          end
        end
      end
      ST_OWN_CMP: begin
        if ((i_q == '0) || (acc[79:0] < best)) begin
          best      <= acc[79:0];
          res_owner <= i_q[IW-1:0];
        end
        i_q <= i_q + CNTW'(1);
      end
      ST_RESULT: begin
        if (out_free) begin
          answer_kind <= (func_q == FUNC_NEAR);
          owner_index <= res_owner;
          is_near     <= near_res;
        end
      end
      default: ;
    endcase
  end

endmodule
